// File: design/three_class_priority_queue_core_defines.svh
`ifndef THREE_CLASS_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define THREE_CLASS_PRIORITY_QUEUE_CORE_DEFINES_SVH

// check a condition in the same cycle
`define TCPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcpq: same-cycle check failed");

// check a condition in the next cycle
`define TCPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcpq: next-cycle check failed");

`endif

// File: design/tcpq_pkg.sv
`timescale 1ns / 1ps

package tcpq_pkg;

	localparam int CAPACITY  = 16;
	localparam int ID_BITS   = 16;
	localparam int MAX_SERVE = 16;

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int FUNC_W    = 2;
	localparam int PORT_ID_W = 16;
	localparam int CLS_W     = 2;
	localparam int SCNT_W    = 5;
	localparam int STAT_W    = 3;
	localparam int OCC_W     = 5;
	localparam int CMP_W     = (CNT_W > SCNT_W) ? CNT_W : SCNT_W;

	localparam logic [FUNC_W-1:0] F_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] F_CALL   = 2'd1;
	localparam logic [FUNC_W-1:0] F_REMOVE = 2'd2;
	localparam logic [FUNC_W-1:0] F_UNUSED = 2'd3;

	localparam logic [CLS_W-1:0] CLS_LOWEST = 2'd2;

	localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STAT_W-1:0] ST_SERVED    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NONE_LEFT = 3'd3;
	localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [CLS_W-1:0]   cls;
	} entry_t;

	localparam int ENT_W = $bits(entry_t);

	// map a queue position to a slot of the circular store
	function automatic logic [PTR_W-1:0] wrap_idx(logic [PTR_W-1:0] base,
			logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(CAPACITY)) begin
			sum = sum - (CNT_W + 1)'(CAPACITY);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

// File: design/tcpq_ram.sv
`timescale 1ns / 1ps

module tcpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/three_class_priority_queue_core.sv
`timescale 1ns / 1ps
// Insert and remove first scan the queue, then shift entries one slot per cycle;
// a call shows one served result per cycle, then a none-left result if the queue runs dry.
// Rejected insert, empty call: result in the cycle after the request. Zero-count call: none.
// Throughput: one request at a time; busy stays high until the last result is shown.
// The rate is set by the walk over the entry memory, one read port, one entry per cycle.
// Reset empties the queue; the entry memory itself is not cleared.

`include "three_class_priority_queue_core_defines.svh"

module three_class_priority_queue_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [tcpq_pkg::FUNC_W-1:0]    func,
	input  logic [tcpq_pkg::PORT_ID_W-1:0] guest_id,
	input  logic [tcpq_pkg::CLS_W-1:0]     guest_class,
	input  logic [tcpq_pkg::SCNT_W-1:0]    serve_count,
	output logic                         strobe,
	output logic [tcpq_pkg::STAT_W-1:0]    status,
	output logic [tcpq_pkg::PORT_ID_W-1:0] served_id,
	output logic [tcpq_pkg::CLS_W-1:0]     served_class,
	output logic [tcpq_pkg::OCC_W-1:0]     occupancy,
	output logic                         last
);

	import tcpq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_POP
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FUNC_W-1:0]  func_q;
	logic [ID_BITS-1:0] id_q;
	logic [CLS_W-1:0]   cls_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   nserve_q;
	logic [CNT_W-1:0]   rem_q;
	logic               none_q;
	logic [ID_BITS-1:0] rid_q;
	logic [CLS_W-1:0]   rcls_q;
	logic               vld_s1;
	logic [CNT_W-1:0]   idx_s1;

	logic                 strobe_q;
	logic [STAT_W-1:0]    status_q;
	logic [PORT_ID_W-1:0] sid_q;
	logic [CLS_W-1:0]     scls_q;
	logic [OCC_W-1:0]     occ_q;
	logic                 last_q;

	logic [CNT_W-1:0] rd_lidx;
	logic [CNT_W-1:0] wr_lidx;
	logic             mem_we;
	entry_t           mem_wdata;
	entry_t           rd_ent;
	logic [ENT_W-1:0] mem_rdata;

	logic [CLS_W-1:0]  cls_in;
	logic [SCNT_W-1:0] req_in;
	logic [CMP_W-1:0]  req_cmp;
	logic [CMP_W-1:0]  cnt_cmp;
	logic              full;
	logic              scan_hit;

	assign busy         = (state_q != S_IDLE);
	assign strobe       = strobe_q;
	assign status       = status_q;
	assign served_id    = sid_q;
	assign served_class = scls_q;
	assign occupancy    = occ_q;
	assign last         = last_q;

	assign rd_ent  = entry_t'(mem_rdata);
	assign cls_in  = (guest_class > CLS_LOWEST) ? CLS_LOWEST : guest_class;
	assign req_in  = (serve_count > SCNT_W'(MAX_SERVE)) ? SCNT_W'(MAX_SERVE) : serve_count;
	assign req_cmp = CMP_W'(req_in);
	assign cnt_cmp = CMP_W'(cnt_q);
	assign full    = (cnt_q >= CNT_W'(CAPACITY));

	assign scan_hit = (func_q == F_INSERT) ? (rd_ent.cls > cls_q) : (rd_ent.id == id_q);

	assign rd_lidx = (state_q == S_SHIFT_UP) ? (idx_q - 1'b1) : idx_q;

	always_comb begin
		mem_we    = 1'b0;
		wr_lidx   = idx_s1;
		mem_wdata = rd_ent;
		case (state_q)
			S_SHIFT_UP: begin
				if (vld_s1) begin
					mem_we  = 1'b1;
					wr_lidx = idx_s1 + 1'b1;
				end else if (idx_q <= pos_q) begin
					mem_we       = 1'b1;
					wr_lidx      = pos_q;
					mem_wdata.id  = id_q;
					mem_wdata.cls = cls_q;
				end
			end
			S_SHIFT_DN: begin
				if (vld_s1) begin
					mem_we  = 1'b1;
					wr_lidx = idx_s1 - 1'b1;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	tcpq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(wrap_idx(head_q, wr_lidx)),
		.wdata(mem_wdata),
		.raddr(wrap_idx(head_q, rd_lidx)),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			cnt_q    <= '0;
			func_q   <= F_INSERT;
			id_q     <= '0;
			cls_q    <= '0;
			idx_q    <= '0;
			pos_q    <= '0;
			nserve_q <= '0;
			rem_q    <= '0;
			none_q   <= 1'b0;
			rid_q    <= '0;
			rcls_q   <= '0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
			strobe_q <= 1'b0;
			status_q <= ST_INSERTED;
			sid_q    <= '0;
			scls_q   <= '0;
			occ_q    <= '0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q <= func;
						id_q   <= ID_BITS'(guest_id);
						cls_q  <= cls_in;
						idx_q  <= '0;
						vld_s1 <= 1'b0;
						case (func)
							F_INSERT: begin
								if (full) begin
									strobe_q <= 1'b1;
									last_q   <= 1'b1;
									status_q <= ST_FULL;
									sid_q    <= '0;
									scls_q   <= '0;
									occ_q    <= OCC_W'(cnt_q);
								end else begin
									state_q <= S_SCAN;
								end
							end
							F_CALL: begin
								if (req_in == '0) begin
									state_q <= S_IDLE;
								end else if (cnt_q == '0) begin
									strobe_q <= 1'b1;
									last_q   <= 1'b1;
									status_q <= ST_NONE_LEFT;
									sid_q    <= '0;
									scls_q   <= '0;
									occ_q    <= '0;
								end else begin
									if (req_cmp <= cnt_cmp) begin
										nserve_q <= CNT_W'(req_cmp);
										rem_q    <= CNT_W'(req_cmp);
									end else begin
										nserve_q <= cnt_q;
										rem_q    <= cnt_q;
									end
									none_q  <= (req_cmp > cnt_cmp);
									state_q <= S_POP;
								end
							end
							F_REMOVE: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (vld_s1 && scan_hit) begin
						vld_s1 <= 1'b0;
						pos_q  <= idx_s1;
						if (func_q == F_INSERT) begin
							idx_q   <= cnt_q;
							state_q <= S_SHIFT_UP;
						end else begin
							rid_q   <= rd_ent.id;
							rcls_q  <= rd_ent.cls;
							idx_q   <= idx_s1 + 1'b1;
							state_q <= S_SHIFT_DN;
						end
					end else if (idx_q < cnt_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= idx_q;
						idx_q  <= idx_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							if (func_q == F_INSERT) begin
								pos_q   <= cnt_q;
								idx_q   <= cnt_q;
								state_q <= S_SHIFT_UP;
							end else begin
								strobe_q <= 1'b1;
								last_q   <= 1'b1;
								status_q <= ST_NOT_FOUND;
								sid_q    <= '0;
								scls_q   <= '0;
								occ_q    <= OCC_W'(cnt_q);
								state_q  <= S_IDLE;
							end
						end
					end
				end
				S_SHIFT_UP: begin
					if (idx_q > pos_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= idx_q - 1'b1;
						idx_q  <= idx_q - 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							cnt_q    <= cnt_q + 1'b1;
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
							status_q <= ST_INSERTED;
							sid_q    <= '0;
							scls_q   <= '0;
							occ_q    <= OCC_W'(cnt_q + 1'b1);
							state_q  <= S_IDLE;
						end
					end
				end
				S_SHIFT_DN: begin
					if (idx_q < cnt_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= idx_q;
						idx_q  <= idx_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							cnt_q    <= cnt_q - 1'b1;
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
							status_q <= ST_REMOVED;
							sid_q    <= PORT_ID_W'(rid_q);
							scls_q   <= rcls_q;
							occ_q    <= OCC_W'(cnt_q - 1'b1);
							state_q  <= S_IDLE;
						end
					end
				end
				S_POP: begin
					if (idx_q < nserve_q) begin
						vld_s1 <= 1'b1;
						idx_q  <= idx_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						cnt_q    <= cnt_q - 1'b1;
						rem_q    <= rem_q - 1'b1;
						strobe_q <= 1'b1;
						last_q   <= (rem_q == CNT_W'(1)) && !none_q;
						status_q <= ST_SERVED;
						sid_q    <= PORT_ID_W'(rd_ent.id);
						scls_q   <= rd_ent.cls;
						occ_q    <= OCC_W'(cnt_q - 1'b1);
						if ((rem_q == CNT_W'(1)) && !none_q) begin
							head_q  <= wrap_idx(head_q, nserve_q);
							state_q <= S_IDLE;
						end
					end else if (rem_q == '0) begin
						strobe_q <= 1'b1;
						last_q   <= 1'b1;
						status_q <= ST_NONE_LEFT;
						sid_q    <= '0;
						scls_q   <= '0;
						occ_q    <= OCC_W'(cnt_q);
						head_q   <= wrap_idx(head_q, nserve_q);
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TCPQ_ASSERT_SAME(a_last_frees, clk, arst_n, strobe_q && last_q, !busy)
	`TCPQ_ASSERT_NEXT(a_full_reject, clk, arst_n,
		start && !busy && (func == F_INSERT) && full,
		strobe && last && (status == ST_FULL))
	`TCPQ_ASSERT_SAME(a_idle_no_write, clk, arst_n, state_q == S_IDLE, !mem_we)
	`TCPQ_ASSERT_SAME(a_cnt_bound, clk, arst_n, strobe_q, cnt_q <= CNT_W'(CAPACITY))

endmodule

// File: test/guest_queue_checker.sv
`timescale 1ns / 1ps

module guest_queue_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [tcpq_pkg::FUNC_W-1:0]    func,
	input  logic [tcpq_pkg::PORT_ID_W-1:0] guest_id,
	input  logic [tcpq_pkg::CLS_W-1:0]     guest_class,
	input  logic [tcpq_pkg::SCNT_W-1:0]    serve_count,
	input  logic                           strobe,
	input  logic [tcpq_pkg::STAT_W-1:0]    status,
	input  logic [tcpq_pkg::PORT_ID_W-1:0] served_id,
	input  logic [tcpq_pkg::CLS_W-1:0]     served_class,
	input  logic [tcpq_pkg::OCC_W-1:0]     occupancy,
	input  logic                           last,
	output int                             pending,
	output int                             errors
);
	import tcpq_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0]    st;
		logic [PORT_ID_W-1:0] id;
		logic [CLS_W-1:0]     cls;
		logic [OCC_W-1:0]     occ;
		logic                 fin;
	} outcome_t;

	logic [ID_BITS-1:0] guest_ids [CAPACITY];
	logic [CLS_W-1:0]   guest_classes [CAPACITY];
	int unsigned        held = 0;
	outcome_t           awaited [$];
	int                 outstanding = 0;
	int                 fail_count = 0;

	assign pending = outstanding;
	assign errors  = fail_count;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: guest queue mismatch: %s got %0h, want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic queue_outcome(input logic [STAT_W-1:0] st, input logic [ID_BITS-1:0] id,
			input logic [CLS_W-1:0] cls);
		outcome_t o;
		o.st  = st;
		o.id  = PORT_ID_W'(id);
		o.cls = cls;
		o.occ = OCC_W'(held);
		o.fin = 1'b0;
		awaited.push_back(o);
	endtask

	// close the gap left by the entry at pos
	task automatic close_gap(input int unsigned pos);
		int unsigned i;
		for (i = pos; i + 1 < held && i + 1 < CAPACITY; i++) begin
			guest_ids[i]     = guest_ids[i + 1];
			guest_classes[i] = guest_classes[i + 1];
		end
		held--;
	endtask

	task automatic model_request(input logic [FUNC_W-1:0] f, input logic [PORT_ID_W-1:0] id_in,
			input logic [CLS_W-1:0] cls_in, input logic [SCNT_W-1:0] cnt_in);
		logic [ID_BITS-1:0] id;
		logic [CLS_W-1:0]   cls;
		logic [ID_BITS-1:0] pid;
		logic [CLS_W-1:0]   pcls;
		int unsigned        pos;
		int unsigned        i;
		int unsigned        n;
		int unsigned        k;
		int                 before_size;
		bit                 dry;
		id          = ID_BITS'(id_in);
		cls         = (cls_in > CLS_LOWEST) ? CLS_LOWEST : cls_in;
		before_size = awaited.size();
		dry         = 1'b0;
		case (f)
			F_INSERT: begin
				if (held >= CAPACITY) begin
					queue_outcome(ST_FULL, '0, '0);
				end else begin
					pos = 0;
					while (pos < held && guest_classes[pos] <= cls) pos++;
					for (i = held; i > pos; i--) begin
						guest_ids[i]     = guest_ids[i - 1];
						guest_classes[i] = guest_classes[i - 1];
					end
					guest_ids[pos]     = id;
					guest_classes[pos] = cls;
					held++;
					queue_outcome(ST_INSERTED, '0, '0);
				end
			end
			F_CALL: begin
				n = (cnt_in > MAX_SERVE) ? MAX_SERVE : cnt_in;
				for (k = 0; k < n && !dry; k++) begin
					if (held == 0) begin
						queue_outcome(ST_NONE_LEFT, '0, '0);
						dry = 1'b1;
					end else begin
						pid  = guest_ids[0];
						pcls = guest_classes[0];
						close_gap(0);
						queue_outcome(ST_SERVED, pid, pcls);
					end
				end
			end
			F_REMOVE: begin
				pos = 0;
				while (pos < held && guest_ids[pos] != id) pos++;
				if (pos >= held) begin
					queue_outcome(ST_NOT_FOUND, '0, '0);
				end else begin
					pid  = guest_ids[pos];
					pcls = guest_classes[pos];
					close_gap(pos);
					queue_outcome(ST_REMOVED, pid, pcls);
				end
			end
			default: begin
			end
		endcase
		if (awaited.size() > before_size) begin
			awaited[awaited.size() - 1].fin = 1'b1;
		end
	endtask

	task automatic check_result();
		outcome_t want;
		if (awaited.size() == 0) begin
			report_mismatch("unrequested result, status", 32'(status), 32'hffff_ffff);
		end else begin
			want = awaited.pop_front();
			if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
			if (served_id !== want.id) report_mismatch("served_id", 32'(served_id), 32'(want.id));
			if (served_class !== want.cls) begin
				report_mismatch("served_class", 32'(served_class), 32'(want.cls));
			end
			if (occupancy !== want.occ) begin
				report_mismatch("occupancy", 32'(occupancy), 32'(want.occ));
			end
			if (last !== want.fin) report_mismatch("last", 32'(last), 32'(want.fin));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			awaited.delete();
			outstanding = 0;
		end else begin
			if (strobe === 1'b1) check_result();
			if (start && !busy) model_request(func, guest_id, guest_class, serve_count);
			outstanding = awaited.size();
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import tcpq_pkg::*;

	localparam int RANDOM_ITEMS = 128;
	localparam int CYCLE_LIMIT  = 200000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [FUNC_W-1:0]    func;
	logic [PORT_ID_W-1:0] guest_id;
	logic [CLS_W-1:0]     guest_class;
	logic [SCNT_W-1:0]    serve_count;
	logic                 strobe;
	logic [STAT_W-1:0]    status;
	logic [PORT_ID_W-1:0] served_id;
	logic [CLS_W-1:0]     served_class;
	logic [OCC_W-1:0]     occupancy;
	logic                 last;
	int                   pending;
	int                   errors;
	int                   cycles = 0;

	logic [PORT_ID_W-1:0] id_pool [8] = '{16'h0000, 16'hffff, 16'h0001, 16'h8000,
		16'h1234, 16'h5a5a, 16'h00ff, 16'h7fff};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	three_class_priority_queue_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.guest_id     (guest_id),
		.guest_class  (guest_class),
		.serve_count  (serve_count),
		.strobe       (strobe),
		.status       (status),
		.served_id    (served_id),
		.served_class (served_class),
		.occupancy    (occupancy),
		.last         (last)
	);

	guest_queue_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.guest_id     (guest_id),
		.guest_class  (guest_class),
		.serve_count  (serve_count),
		.strobe       (strobe),
		.status       (status),
		.served_id    (served_id),
		.served_class (served_class),
		.occupancy    (occupancy),
		.last         (last),
		.pending      (pending),
		.errors       (errors)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** three_class_priority_queue_core: FAILED **");
			$finish;
		end
	end

	// hold the request until the block takes it
	task automatic post_request(input logic [FUNC_W-1:0] f, input logic [PORT_ID_W-1:0] id,
			input logic [CLS_W-1:0] cls, input logic [SCNT_W-1:0] cnt);
		start       <= 1'b1;
		func        <= f;
		guest_id    <= id;
		guest_class <= cls;
		serve_count <= cnt;
		do @(posedge clk); while (busy);
	endtask

	task automatic maybe_idle(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// drop start and wait until every expected result is in
	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		@(posedge clk);
	endtask

	function automatic logic [PORT_ID_W-1:0] pick_id();
		if ($urandom_range(0, 1) == 0) return id_pool[$urandom_range(0, 7)];
		return PORT_ID_W'($urandom());
	endfunction

	initial begin
		int i;
		int r;
		int pct;
		arst_n      = 1'b0;
		start       = 1'b0;
		func        = F_INSERT;
		guest_id    = '0;
		guest_class = '0;
		serve_count = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		post_request(F_CALL, 16'h0000, 2'd0, 5'd1);
		post_request(F_REMOVE, 16'h0000, 2'd0, 5'd0);
		post_request(F_UNUSED, 16'hffff, 2'd3, 5'd31);
		post_request(F_INSERT, 16'hffff, 2'd3, 5'd0);
		post_request(F_INSERT, 16'h0000, 2'd0, 5'd0);
		post_request(F_INSERT, 16'h1234, 2'd1, 5'd0);
		post_request(F_INSERT, 16'h5a5a, 2'd2, 5'd0);
		post_request(F_REMOVE, 16'hffff, 2'd0, 5'd0);
		post_request(F_REMOVE, 16'h4321, 2'd0, 5'd0);
		post_request(F_CALL, 16'h0000, 2'd0, 5'd0);
		post_request(F_CALL, 16'hffff, 2'd3, 5'd31);

		// fill past capacity, then empty it in one call
		for (i = 0; i < 20; i++) begin
			maybe_idle(26);
			post_request(F_INSERT, pick_id(), CLS_W'($urandom_range(0, 3)), SCNT_W'($urandom()));
		end
		maybe_idle(26);
		post_request(F_CALL, pick_id(), 2'd0, 5'd16);

		i = 0;
		while (i < RANDOM_ITEMS) begin
			pct = (i >= 60 && i < 100) ? 0 : 26;
			if (i == 100) wait_drained();
			maybe_idle(pct);
			r = $urandom_range(0, 99);
			if (r < 5) begin
				post_request(F_UNUSED, PORT_ID_W'($urandom()), CLS_W'($urandom_range(0, 3)),
					SCNT_W'($urandom()));
			end else if (r < 52) begin
				post_request(F_INSERT, pick_id(), CLS_W'($urandom_range(0, 3)),
					SCNT_W'($urandom()));
				i++;
			end else if (r < 75) begin
				post_request(F_CALL, PORT_ID_W'($urandom()), CLS_W'($urandom_range(0, 3)),
					($urandom_range(0, 3) == 0) ? SCNT_W'($urandom_range(0, 31))
						: SCNT_W'($urandom_range(1, 3)));
				i++;
			end else begin
				post_request(F_REMOVE, pick_id(), CLS_W'($urandom_range(0, 3)),
					SCNT_W'($urandom()));
				i++;
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("** three_class_priority_queue_core: PASSED **");
		end else begin
			$display("** three_class_priority_queue_core: FAILED **");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/tcpq_pkg.sv
design/tcpq_ram.sv
design/three_class_priority_queue_core.sv
test/guest_queue_checker.sv
test/tb.sv
